[sv/swsu_pkg.sv]
package swsu_pkg;

  localparam int DATA_W       = 16;
  localparam int TICK_W       = 22;
  localparam int CH_W         = 3;
  localparam int COLOR_W      = 3;
  localparam int NUM_ENV      = 4;
  localparam int NUM_EXT      = 7;
  localparam logic [TICK_W-1:0] WINDOW_RESET = 22'd30000;
  localparam logic [TICK_W-1:0] TICK_MAX     = {TICK_W{1'b1}};
  localparam logic [DATA_W-1:0] BIN_MAX      = {DATA_W{1'b1}};
  localparam logic signed [DATA_W-1:0] EXT_MAX_RESET = 16'sh8000;
  localparam logic signed [DATA_W-1:0] EXT_MIN_RESET = 16'sh7fff;
  localparam logic [CH_W-1:0] CH_COLOUR = 3'd4;
  localparam logic [CH_W-1:0] CH_LAST   = 3'd7;
  localparam logic [CH_W-1:0] CH_FIRST_AXIS = 3'd5;
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_LOAD,
    S_DIV,
    S_EMIT,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic           rec_en;
    logic           tick_en;
    logic           scan_init;
    logic           scan_en;
    logic           div_load;
    logic           div_step;
    logic           clear;
    logic [5:0]     cnt;
    logic [CH_W-1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic report_due;
  } dp_stat_t;

endpackage

[sv/swsu_if.sv]
interface swsu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [swsu_pkg::DATA_W-1:0]  temperature;
  logic signed [swsu_pkg::DATA_W-1:0]  humidity;
  logic signed [swsu_pkg::DATA_W-1:0]  brightness;
  logic signed [swsu_pkg::DATA_W-1:0]  soil;
  logic signed [swsu_pkg::DATA_W-1:0]  accel_x;
  logic signed [swsu_pkg::DATA_W-1:0]  accel_y;
  logic signed [swsu_pkg::DATA_W-1:0]  accel_z;
  logic [swsu_pkg::COLOR_W-1:0]        color_index;

  modport source (output valid, cmd, temperature, humidity, brightness, soil,
                  accel_x, accel_y, accel_z, color_index, input ready);
  modport sink (input valid, cmd, temperature, humidity, brightness, soil,
                accel_x, accel_y, accel_z, color_index, output ready);
endinterface

interface swsu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [swsu_pkg::CH_W-1:0]           channel;
  logic signed [swsu_pkg::DATA_W-1:0]  mean_value;
  logic signed [swsu_pkg::DATA_W-1:0]  max_value;
  logic signed [swsu_pkg::DATA_W-1:0]  min_value;
  logic [swsu_pkg::COLOR_W-1:0]        mode_colour;
  logic [swsu_pkg::DATA_W-1:0]         dominant_count;
  logic [swsu_pkg::DATA_W-1:0]         samples_in_window;
  logic                                 last;

  modport source (output valid, channel, mean_value, max_value, min_value,
                  mode_colour, dominant_count, samples_in_window, last,
                  input ready);
  modport sink (input valid, channel, mean_value, max_value, min_value,
                mode_colour, dominant_count, samples_in_window, last,
                output ready);
endinterface

[sv/swsu_ctrl.sv]
module swsu_ctrl #(
  parameter int NUM_COLORS = 8,
  parameter int SUM_W      = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  swsu_pkg::dp_stat_t stat,
  output swsu_pkg::dp_cmd_t  cmd
);

  swsu_pkg::state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [swsu_pkg::CH_W-1:0] ch, ch_next;
  logic in_acc;

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swsu_pkg::S_IDLE;
      cnt   <= '0;
      ch    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ch_next    = ch;
    case (state)
      swsu_pkg::S_IDLE: begin
        if (in_acc && in_cmd == swsu_pkg::CMD_RECORD) state_next = swsu_pkg::S_CHECK;
      end
      swsu_pkg::S_CHECK: begin
        cnt_next = '0;
        ch_next  = '0;
        state_next = stat.report_due ? swsu_pkg::S_SCAN : swsu_pkg::S_IDLE;
      end
      swsu_pkg::S_SCAN: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(NUM_COLORS - 1)) state_next = swsu_pkg::S_LOAD;
      end
      swsu_pkg::S_LOAD: begin
        cnt_next = '0;
        state_next = (ch < swsu_pkg::CH_COLOUR) ? swsu_pkg::S_DIV : swsu_pkg::S_EMIT;
      end
      swsu_pkg::S_DIV: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(SUM_W - 1)) state_next = swsu_pkg::S_EMIT;
      end
      swsu_pkg::S_EMIT: begin
        if (out_ready) begin
          if (ch == swsu_pkg::CH_LAST) begin
            state_next = swsu_pkg::S_CLEAR;
          end else begin
            ch_next = ch + 3'd1;
            state_next = swsu_pkg::S_LOAD;
          end
        end
      end
      swsu_pkg::S_CLEAR: state_next = swsu_pkg::S_IDLE;
      default: state_next = swsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.cnt       = cnt;
    cmd.ch        = ch;
    case (state)
      swsu_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.rec_en  = in_valid && in_cmd == swsu_pkg::CMD_RECORD;
        cmd.tick_en = in_valid && in_cmd == swsu_pkg::CMD_TICK;
      end
      swsu_pkg::S_CHECK: cmd.scan_init = 1'b1;
      swsu_pkg::S_SCAN:  cmd.scan_en   = 1'b1;
      swsu_pkg::S_LOAD:  cmd.div_load  = 1'b1;
      swsu_pkg::S_DIV:   cmd.div_step  = 1'b1;
      swsu_pkg::S_EMIT:  out_valid     = 1'b1;
      swsu_pkg::S_CLEAR: cmd.clear     = 1'b1;
      default: ;
    endcase
  end

endmodule

[sv/swsu_datapath.sv]
module swsu_datapath #(
  parameter int NUM_COLORS = 8,
  parameter int COUNT_BITS = 16,
  parameter int SUM_W      = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swsu_pkg::TICK_W-1:0]      cfg_wdata,
  input  logic signed [swsu_pkg::DATA_W-1:0] smp [swsu_pkg::NUM_EXT],
  input  logic [swsu_pkg::COLOR_W-1:0]     color_index,
  input  swsu_pkg::dp_cmd_t                cmd,
  output swsu_pkg::dp_stat_t               stat,
  output logic [swsu_pkg::CH_W-1:0]        channel,
  output logic signed [swsu_pkg::DATA_W-1:0] mean_value,
  output logic signed [swsu_pkg::DATA_W-1:0] max_value,
  output logic signed [swsu_pkg::DATA_W-1:0] min_value,
  output logic [swsu_pkg::COLOR_W-1:0]     mode_colour,
  output logic [swsu_pkg::DATA_W-1:0]      dominant_count,
  output logic [swsu_pkg::DATA_W-1:0]      samples_in_window,
  output logic                             last
);

  localparam int IW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [swsu_pkg::TICK_W-1:0] window_ms, elapsed;
  logic [COUNT_BITS-1:0] count;
  logic signed [SUM_W-1:0] sums [swsu_pkg::NUM_ENV];
  logic signed [swsu_pkg::DATA_W-1:0] maxima [swsu_pkg::NUM_EXT];
  logic signed [swsu_pkg::DATA_W-1:0] minima [swsu_pkg::NUM_EXT];
  logic [swsu_pkg::DATA_W-1:0] hist [NUM_COLORS];
  logic [IW-1:0] hidx, best;
  logic [swsu_pkg::DATA_W-1:0] hval, bestn;
  logic [SUM_W-1:0] quo;
  logic [COUNT_BITS:0] rem, rem_sh;
  logic neg;
  logic col_ok;
  logic signed [SUM_W-1:0] sel_sum;
  logic [2:0] ext_idx;

  assign col_ok = 32'(color_index) < NUM_COLORS;
  assign hidx   = cmd.scan_en ? cmd.cnt[IW-1:0] : IW'(color_index);
  assign hval   = hist[hidx];
  assign sel_sum = sums[cmd.ch[1:0]];
  assign rem_sh = {rem[COUNT_BITS-1:0], quo[SUM_W-1]};
  assign stat.report_due = (elapsed >= window_ms) || (count == COUNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) window_ms <= swsu_pkg::WINDOW_RESET;
    else if (cfg_we) window_ms <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      elapsed <= '0;
      count   <= '0;
      for (int i = 0; i < swsu_pkg::NUM_ENV; i++) sums[i] <= '0;
      for (int i = 0; i < swsu_pkg::NUM_EXT; i++) begin
        maxima[i] <= swsu_pkg::EXT_MAX_RESET;
        minima[i] <= swsu_pkg::EXT_MIN_RESET;
      end
      for (int i = 0; i < NUM_COLORS; i++) hist[i] <= '0;
    end else begin
      if (cmd.tick_en && elapsed != swsu_pkg::TICK_MAX) elapsed <= elapsed + 22'd1;
      if (cmd.rec_en) begin
        for (int i = 0; i < swsu_pkg::NUM_EXT; i++) begin
          if (smp[i] > maxima[i]) maxima[i] <= smp[i];
          if (smp[i] < minima[i]) minima[i] <= smp[i];
        end
        for (int i = 0; i < swsu_pkg::NUM_ENV; i++) sums[i] <= sums[i] + SUM_W'(smp[i]);
        if (col_ok && hval != swsu_pkg::BIN_MAX) hist[hidx] <= hval + 16'd1;
        if (count != COUNT_MAX) count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best  <= '0;
      bestn <= '0;
    end else if (cmd.scan_en && hval > bestn) begin
      best  <= hidx;
      bestn <= hval;
    end
    if (cmd.div_load) begin
      neg <= sel_sum[SUM_W-1];
      quo <= sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, count}) begin
        rem <= rem_sh - {1'b0, count};
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign ext_idx = (cmd.ch < swsu_pkg::CH_COLOUR) ? cmd.ch : cmd.ch - 3'd1;

  always_comb begin
    channel        = cmd.ch;
    mean_value     = '0;
    max_value      = '0;
    min_value      = '0;
    mode_colour    = '0;
    dominant_count = '0;
    last           = cmd.ch == swsu_pkg::CH_LAST;
    if (32'(count) > 32'(swsu_pkg::BIN_MAX)) samples_in_window = swsu_pkg::BIN_MAX;
    else samples_in_window = 16'(count);
    if (cmd.ch == swsu_pkg::CH_COLOUR) begin
      mode_colour    = 3'(best);
      dominant_count = bestn;
    end else begin
      max_value = maxima[ext_idx];
      min_value = minima[ext_idx];
      if (cmd.ch < swsu_pkg::CH_COLOUR) mean_value = 16'(neg ? -quo : quo);
    end
  end

endmodule

[sv/sensor_window_statistics_unit.sv]
// Windowed min / max / mean and colour-mode statistics over sensor records.
// samples: sink channel, one transaction per record (cmd 0) or per
//   millisecond tick (cmd 1). ready is high only while the block is idle.
// reports: source channel, eight transactions per report, channels 0..7,
//   last set on channel 7.
// cfg_we / cfg_wdata: write window_ms; write only while idle.
// A tick is handled in idle; a record passes a check state and returns
//   to idle when no report is due. A report runs the check, a histogram
//   scan of the NUM_COLORS bins, then per environment channel a load, the
//   shift-subtract divide of the (16 + COUNT_BITS)-bit sum by the sample
//   count and an output transaction, a load and an output transaction for
//   each other channel, and a clearing state.
// When the receiver stalls, the current report transaction holds and no
//   sample is taken until the report completes.
// Reset (rst, synchronous) clears all statistics and the tick timer and
//   sets window_ms to 30000.
module sensor_window_statistics_unit #(
  parameter int NUM_COLORS = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [swsu_pkg::TICK_W-1:0] cfg_wdata,
  swsu_in_if.sink                     samples,
  swsu_out_if.source                  reports
);

  localparam int SUM_W = swsu_pkg::DATA_W + COUNT_BITS;

  swsu_pkg::dp_cmd_t  cmd;
  swsu_pkg::dp_stat_t stat;
  logic signed [swsu_pkg::DATA_W-1:0] smp [swsu_pkg::NUM_EXT];

  assign smp[0] = samples.temperature;
  assign smp[1] = samples.humidity;
  assign smp[2] = samples.brightness;
  assign smp[3] = samples.soil;
  assign smp[4] = samples.accel_x;
  assign smp[5] = samples.accel_y;
  assign smp[6] = samples.accel_z;

  swsu_ctrl #(.NUM_COLORS(NUM_COLORS), .SUM_W(SUM_W)) u_ctrl (
    .clk, .rst,
    .in_valid  (samples.valid),
    .in_cmd    (samples.cmd),
    .in_ready  (samples.ready),
    .out_valid (reports.valid),
    .out_ready (reports.ready),
    .stat, .cmd
  );

  swsu_datapath #(.NUM_COLORS(NUM_COLORS), .COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_dp (
    .clk, .rst, .cfg_we, .cfg_wdata, .smp,
    .color_index       (samples.color_index),
    .cmd, .stat,
    .channel           (reports.channel),
    .mean_value        (reports.mean_value),
    .max_value         (reports.max_value),
    .min_value         (reports.min_value),
    .mode_colour       (reports.mode_colour),
    .dominant_count    (reports.dominant_count),
    .samples_in_window (reports.samples_in_window),
    .last              (reports.last)
  );

endmodule

[sv/swsu_checker.sv]
module swsu_sva (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [swsu_pkg::CH_W-1:0]   channel,
  input logic [swsu_pkg::DATA_W-1:0] dominant_count,
  input logic                        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel))
    else $error("report transaction dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("sample taken during report");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (channel == swsu_pkg::CH_LAST)))
    else $error("last flag on wrong channel");

  a_dom: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel != swsu_pkg::CH_COLOUR |-> dominant_count == '0)
    else $error("dominant count on non-colour channel");

endmodule

bind sensor_window_statistics_unit swsu_sva u_swsu_sva (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (samples.ready),
  .out_valid      (reports.valid),
  .out_ready      (reports.ready),
  .channel        (reports.channel),
  .dominant_count (reports.dominant_count),
  .last           (reports.last)
);
